// File: hdl/assert_macros.svh
// Assertion macros for the RTL; bmp_back is the only file that includes them.
// Self-contained; simulation builds get checks, synthesis builds get nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_AT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst, cond) \
   `ASSERT_AT(lbl, clk, rst, !(cond))
`else
`define ASSERT_AT(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

// File: hdl/bmp_pkg.sv
// Shared widths, constants and the job type of the binomial unit.
// No dependencies.
package bmp_pkg;
   localparam int ROW_W       = 10;
   localparam int COEF_W      = 14;
   localparam int MAX_ROWS    = 2 ** ROW_W;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam logic [COEF_W-1:0] MOD_RESET = COEF_W'(10007);

   typedef struct packed {
      logic [ROW_W-1:0] row_n;
      logic [ROW_W-1:0] col_k;
      logic             zero;
   } bmp_job_type;
endpackage

// File: hdl/bmp_front.sv
// Front stage: takes query beats, flags columns past the row, feeds the queue.
// Depends on bmp_pkg.
module bmp_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [bmp_pkg::ROW_W-1:0] req_row_n,
   input  logic [bmp_pkg::ROW_W-1:0] req_col_k,
   output logic                     push,
   output bmp_pkg::bmp_job_type     push_job,
   input  logic                     q_full
);
   import bmp_pkg::*;

   logic        f_vld_ff, f_vld_in;
   bmp_job_type f_job_ff, f_job_in;
   logic        accept;

   assign req_stall = f_vld_ff && q_full;
   assign accept    = req_valid && !req_stall;
   assign push      = f_vld_ff && !q_full;
   assign push_job  = f_job_ff;

   always_comb begin
      f_vld_in = accept || (f_vld_ff && !push);
      f_job_in = f_job_ff;
      if (accept) begin
         f_job_in.row_n = req_row_n;
         f_job_in.col_k = req_col_k;
         f_job_in.zero  = req_col_k > req_row_n;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff <= 1'b0;
      end else begin
         f_vld_ff <= f_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      f_job_ff <= f_job_in;
   end
endmodule

// File: hdl/bmp_queue.sv
// Short job queue between the front stage and the triangle builder.
// Depends on bmp_pkg.
module bmp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  bmp_pkg::bmp_job_type push_job,
   output logic                 full,
   input  logic                 pop,
   output logic                 q_valid,
   output bmp_pkg::bmp_job_type q_job
);
   import bmp_pkg::*;

   bmp_job_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]         cnt_ff, cnt_in;
   logic                    do_push, do_pop;

   assign full    = cnt_ff == (QPTR_W+1)'(QUEUE_DEPTH);
   assign q_valid = cnt_ff != '0;
   assign q_job   = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && q_valid;

   function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
      if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + QPTR_W'(1);
   endfunction

   always_comb begin
      wr_ptr_in = do_push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + (QPTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - (QPTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end
endmodule

// File: hdl/bmp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bmp_ram #(
   parameter int WIDTH = 14,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end
endmodule

// File: hdl/bmp_back.sv
// Back end: rebuilds Pascal's triangle in the row store and returns C(n,k).
// Depends on bmp_pkg, bmp_ram and assert_macros.svh.
`include "assert_macros.svh"
module bmp_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [bmp_pkg::COEF_W-1:0] modulus,
   input  logic                      q_valid,
   input  bmp_pkg::bmp_job_type      q_job,
   output logic                      q_pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [bmp_pkg::COEF_W-1:0] rsp_coefficient
);
   import bmp_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_ROW   = 3'd1;
   localparam logic [2:0] ST_SWEEP = 3'd2;
   localparam logic [2:0] ST_READ  = 3'd3;
   localparam logic [2:0] ST_WAITD = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [ROW_W-1:0]  n_ff, n_in;
   logic [ROW_W-1:0]  k_ff, k_in;
   logic [ROW_W-1:0]  row_i_ff, row_i_in;
   logic [ROW_W-1:0]  rd_a_ff, rd_a_in;
   logic [COEF_W-1:0] prev_ff, prev_in;
   logic [COEF_W-1:0] res_ff, res_in;
   logic              out_vld_ff, out_vld_in;
   logic [COEF_W-1:0] out_data_ff, out_data_in;

   logic              wr_en, rd_en, out_load;
   logic [ROW_W-1:0]  wr_addr, rd_addr;
   logic [COEF_W-1:0] wr_data, rd_data;
   logic [COEF_W-1:0] m_eff, one_val, add_mod;
   logic [COEF_W:0]   sum;

   bmp_ram #(.WIDTH(COEF_W), .DEPTH(MAX_ROWS)) u_row_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // modulus zero acts as modulus one
   assign m_eff   = (modulus == '0) ? COEF_W'(1) : modulus;
   assign one_val = (m_eff == COEF_W'(1)) ? '0 : COEF_W'(1);
   assign sum     = {1'b0, prev_ff} + {1'b0, rd_data};
   assign add_mod = (sum >= {1'b0, m_eff}) ? COEF_W'(sum - {1'b0, m_eff})
                                           : sum[COEF_W-1:0];

   always_comb begin
      state_in = state_ff;
      n_in     = n_ff;
      k_in     = k_ff;
      row_i_in = row_i_ff;
      rd_a_in  = rd_a_ff;
      prev_in  = prev_ff;
      res_in   = res_ff;
      q_pop    = 1'b0;
      wr_en    = 1'b0;
      wr_addr  = '0;
      wr_data  = one_val;
      rd_en    = 1'b0;
      rd_addr  = '0;
      out_load = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               n_in  = q_job.row_n;
               k_in  = q_job.col_k;
               if (q_job.zero) begin
                  res_in   = '0;
                  state_in = ST_DONE;
               end else begin
                  wr_en    = 1'b1;
                  row_i_in = ROW_W'(1);
                  state_in = (q_job.row_n == '0) ? ST_READ : ST_ROW;
               end
            end
         end
         ST_ROW: begin
            // new right edge, then sweep the row downward from i-1
            wr_en    = 1'b1;
            wr_addr  = row_i_ff;
            rd_en    = 1'b1;
            rd_addr  = row_i_ff - ROW_W'(1);
            rd_a_in  = row_i_ff - ROW_W'(1);
            state_in = ST_SWEEP;
         end
         ST_SWEEP: begin
            prev_in = rd_data;
            if (rd_a_ff != row_i_ff - ROW_W'(1)) begin
               wr_en   = 1'b1;
               wr_addr = rd_a_ff + ROW_W'(1);
               wr_data = add_mod;
            end
            if (rd_a_ff != '0) begin
               rd_en   = 1'b1;
               rd_addr = rd_a_ff - ROW_W'(1);
               rd_a_in = rd_a_ff - ROW_W'(1);
            end else if (row_i_ff == n_ff) begin
               state_in = ST_READ;
            end else begin
               row_i_in = row_i_ff + ROW_W'(1);
               state_in = ST_ROW;
            end
         end
         ST_READ: begin
            rd_en    = 1'b1;
            rd_addr  = k_ff;
            state_in = ST_WAITD;
         end
         ST_WAITD: begin
            res_in   = rd_data;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!out_vld_ff || !rsp_stall) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      out_data_in = out_load ? res_ff : out_data_ff;
      if (out_load) begin
         out_vld_in = 1'b1;
      end else if (!rsp_stall) begin
         out_vld_in = 1'b0;
      end else begin
         out_vld_in = out_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      k_ff        <= k_in;
      row_i_ff    <= row_i_in;
      rd_a_ff     <= rd_a_in;
      prev_ff     <= prev_in;
      res_ff      <= res_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_coefficient = out_data_ff;

   `ASSERT_NEVER(a_rw_clash, clock, reset, wr_en && rd_en && (wr_addr == rd_addr))
   `ASSERT_AT(a_sweep_bound, clock, reset, (state_ff == ST_SWEEP) |-> (rd_a_ff < row_i_ff))
   `ASSERT_NEVER(a_no_overwrite, clock, reset, out_load && out_vld_ff && rsp_stall)
   `ASSERT_AT(a_load_shows, clock, reset, out_load |=> out_vld_ff)
endmodule

// File: hdl/binomial_mod_pascal_unit.sv
// Binomial coefficient C(n,k) mod a programmable modulus via Pascal's triangle.
//
// Channels: a query beat (req_row_n, req_col_k) is taken when req_valid is high
// and req_stall low; a result beat (rsp_coefficient) leaves when rsp_valid is
// high and rsp_stall low, one per query, in query order. csr_modulus is taken
// when csr_valid is high (csr_ready is always high); write it only while idle.
// A modulus of zero acts as one.
// A query with k > n skips the build and goes straight to the result. Otherwise
// the row store, which has a single read port, is rebuilt in place from row 0 up
// to row n, and C(n,k) is then read from it.
// Throughput is one query at a time in the builder; the front register and a
// two-entry queue take up to three further queries meanwhile.
// Reset (synchronous, high) empties the front register, queue and output register
// and loads the modulus with 10007; the row store needs no clearing.
// A stalled receiver holds the result beat; the builder waits and the queue and
// front register fill, after which req_stall rises.
// Depends on bmp_pkg, bmp_front, bmp_queue, bmp_back.
module binomial_mod_pascal_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [bmp_pkg::ROW_W-1:0]  req_row_n,
   input  logic [bmp_pkg::ROW_W-1:0]  req_col_k,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [bmp_pkg::COEF_W-1:0] rsp_coefficient,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [bmp_pkg::COEF_W-1:0] csr_modulus
);
   import bmp_pkg::*;

   logic [COEF_W-1:0] modulus_ff, modulus_in;
   logic              push, q_full, q_valid, q_pop;
   bmp_job_type       push_job, q_job;

   assign csr_ready  = 1'b1;
   assign modulus_in = (csr_valid && csr_ready) ? csr_modulus : modulus_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= MOD_RESET;
      end else begin
         modulus_ff <= modulus_in;
      end
   end

   bmp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_row_n (req_row_n),
      .req_col_k (req_col_k),
      .push      (push),
      .push_job  (push_job),
      .q_full    (q_full)
   );

   bmp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (q_pop),
      .q_valid  (q_valid),
      .q_job    (q_job)
   );

   bmp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .modulus         (modulus_ff),
      .q_valid         (q_valid),
      .q_job           (q_job),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_coefficient (rsp_coefficient)
   );
endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for binomial_mod_pascal_unit: directed and random C(n,k) queries.
// Expected coefficients come from a Pascal-row predictor kept here; depends on bmp_pkg.
module tb;
   import bmp_pkg::*;

   typedef struct {
      logic [ROW_W-1:0]  row_n;
      logic [ROW_W-1:0]  col_k;
      logic [COEF_W-1:0] coef;
   } coef_expect_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [ROW_W-1:0]  req_row_n;
   logic [ROW_W-1:0]  req_col_k;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [COEF_W-1:0] rsp_coefficient;
   logic              csr_valid;
   logic              csr_ready;
   logic [COEF_W-1:0] csr_modulus;

   coef_expect_type   coef_expect_q[$];
   coef_expect_type   coef_head;
   logic [COEF_W-1:0] modulus_shadow;
   int unsigned       pascal_row [0:MAX_ROWS-1];
   int unsigned       req_idle_pct;
   int unsigned       rsp_idle_pct;
   int unsigned       error_count;

   binomial_mod_pascal_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_row_n       (req_row_n),
      .req_col_k       (req_col_k),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_coefficient (rsp_coefficient),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_modulus     (csr_modulus)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Build rows 0..n in place, right to left, as the block does.
   function automatic logic [COEF_W-1:0] pascal_coef(input logic [ROW_W-1:0] n,
                                                     input logic [ROW_W-1:0] k);
      int unsigned m;
      int          i;
      int          j;
      m = (modulus_shadow == '0) ? 1 : int'(modulus_shadow);
      if (k > n) return '0;
      pascal_row[0] = 1 % m;
      for (i = 1; i <= int'(n); i++) begin
         for (j = i - 1; j >= 1; j--)
            pascal_row[j] = (pascal_row[j] + pascal_row[j-1]) % m;
         pascal_row[i] = 1 % m;
      end
      return COEF_W'(pascal_row[k]);
   endfunction

   task automatic flag_error(input string msg);
      $display("ERROR @%0t: %s", $time, msg);
      error_count++;
   endtask

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
   end

   // Sample at the falling edge; the beat is taken at the next rising edge.
   always @(negedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (coef_expect_q.size() == 0) begin
            flag_error($sformatf("result beat %0d with no query waiting", rsp_coefficient));
         end else begin
            coef_head = coef_expect_q.pop_front();
            if (rsp_coefficient !== coef_head.coef)
               flag_error($sformatf("C(%0d,%0d) mod %0d: got %0d, want %0d",
                                    coef_head.row_n, coef_head.col_k, modulus_shadow,
                                    rsp_coefficient, coef_head.coef));
         end
      end
   end

   task automatic send_query(input logic [ROW_W-1:0] n, input logic [ROW_W-1:0] k);
      coef_expect_type item;
      logic            stalled;
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      item.row_n = n;
      item.col_k = k;
      item.coef  = pascal_coef(n, k);
      coef_expect_q.push_back(item);
      req_valid <= 1'b1;
      req_row_n <= n;
      req_col_k <= k;
      do begin
         @(negedge clock);
         stalled = req_stall;
         @(posedge clock);
      end while (stalled);
   endtask

   // Hold off new queries until every result is back, then let the block settle.
   task automatic wait_results_done();
      req_valid <= 1'b0;
      while (coef_expect_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_modulus(input logic [COEF_W-1:0] value);
      logic ready_seen;
      wait_results_done();
      csr_valid   <= 1'b1;
      csr_modulus <= value;
      do begin
         @(negedge clock);
         ready_seen = csr_ready;
         @(posedge clock);
      end while (!ready_seen);
      csr_valid      <= 1'b0;
      modulus_shadow = value;
   endtask

   task automatic set_idling(input int unsigned req_pct, input int unsigned rsp_pct);
      req_idle_pct = req_pct;
      rsp_idle_pct = rsp_pct;
   endtask

   task automatic test_small_rows();
      send_query(0, 0);
      send_query(1, 0);
      send_query(1, 1);
      send_query(2, 1);
      send_query(5, 2);
      send_query(10, 5);
      send_query(20, 10);
   endtask

   // High row bits get exercised here cheaply, since k > n skips the build.
   task automatic test_column_past_row();
      send_query(0, 1);
      send_query(0, 1023);
      send_query(1, 2);
      send_query(513, 1023);
      send_query(1022, 1023);
      send_query(600, 601);
   endtask

   task automatic test_largest_row();
      send_query(1023, 511);
   endtask

   task automatic test_modulus_extremes();
      write_modulus(2);
      send_query(4, 2);
      send_query(6, 3);
      write_modulus(16383);
      send_query(40, 20);
      send_query(47, 23);
   endtask

   task automatic test_modulus_zero_one();
      write_modulus(0);
      send_query(0, 0);
      send_query(7, 3);
      write_modulus(1);
      send_query(0, 0);
      send_query(9, 4);
   endtask

   task automatic test_random_queries(input int count, input int unsigned mod_lo,
                                      input int unsigned mod_hi);
      int          i;
      int unsigned sel;
      int unsigned n;
      int unsigned k;
      write_modulus(COEF_W'($urandom_range(mod_hi, mod_lo)));
      for (i = 0; i < count; i++) begin
         sel = $urandom_range(99);
         if (sel < 15) begin
            n = $urandom_range(1022, 0);
            k = $urandom_range(1023, n + 1);
         end else if (sel < 20) begin
            n = $urandom_range(160, 49);
            k = $urandom_range(n, 0);
         end else begin
            n = $urandom_range(48, 0);
            k = $urandom_range(n, 0);
         end
         // now and then drain the pipe before the next beat
         if ($urandom_range(99) < 4) wait_results_done();
         send_query(ROW_W'(n), ROW_W'(k));
      end
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_row_n      = '0;
      req_col_k      = '0;
      csr_valid      = 1'b0;
      csr_modulus    = '0;
      modulus_shadow = MOD_RESET;
      error_count    = 0;
      set_idling(25, 55);
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_small_rows();
      test_column_past_row();
      test_largest_row();
      test_modulus_extremes();
      test_modulus_zero_one();

      test_random_queries(35, 2, 16383);
      wait_results_done();
      set_idling(55, 25);
      test_random_queries(35, 2, 31);
      wait_results_done();
      set_idling(0, 0);
      test_random_queries(30, 0, 16383);

      wait_results_done();
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("** binomial_mod_pascal_unit: PASSED **");
      end else begin
         $display("** binomial_mod_pascal_unit: FAILED **");
      end
      $finish;
   end

   initial begin
      #100_000_000;
      $display("timeout: %0d results still outstanding", coef_expect_q.size());
      $display("** binomial_mod_pascal_unit: FAILED **");
      $finish;
   end
endmodule
